// ===== hdl/urxit_pkg.sv =====
package urxit_pkg;

  // Largest buffer that an arm request may ask for.
  localparam logic [15:0] MAX_TRANSFER = 16'd65528;

  // Reset value of the idle timeout register, in ticks.
  localparam logic [31:0] IDLE_TIMEOUT_RST = 32'd100000;

  // Register index of the idle timeout register on the configuration port.
  localparam logic REG_IDLE_TIMEOUT = 1'b0;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_ARM   = 2'd1,
    REQ_ABORT = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    CMD_NOP   = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_ARM   = 2'd2,
    CMD_ABORT = 2'd3
  } cmd_op_e;

  // A classified request, as it travels through the queue.
  typedef struct packed {
    cmd_op_e     op;
    logic        byte_ok;
    logic [7:0]  data;
    logic [31:0] now;
    logic        len_ok;
    logic [15:0] len;
  } cmd_t;

  // One result.
  typedef struct packed {
    logic        store_valid;
    logic [15:0] store_index;
    logic [7:0]  store_data;
    logic        complete;
    logic [15:0] complete_len;
    logic        arm_accepted;
    logic        busy;
  } res_t;

  // Fill status of the command queue.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== hdl/uart_rx_idle_timeout_framer.sv =====
// Receive-transaction framer that sits behind a UART receiver.
// Requests arrive on the in_* channel: a tick (optionally carrying a received
// character and its error flags), an arm request with a buffer length, or an
// abort. Every accepted request produces exactly one result on the out_*
// channel: a byte to store with its buffer index, a completion with the number
// of bytes received, the arm acknowledgement and the busy flag after the request.
// The idle timeout in ticks is set through the APB port at byte address 0 and
// should only be written while no request is in flight.
// A request is classified as it is accepted and written to a short command
// queue; the execution stage pops one command per cycle while the result
// register is free, and loads it. A request passes through the queue and the
// result register to out_valid_o. The sustained rate is one request per cycle
// while the receiver does not stall, bounded only by the combinational compare,
// subtract and increment in the execution stage.
// When the receiver stalls, the result register holds its value and the queue
// absorbs up to QUEUE_DEPTH further requests before in_stall_o is raised.
// Reset empties the queue and the result register, leaves the framer idle with
// a zero byte count, and returns the idle timeout to 100000 ticks.
module uart_rx_idle_timeout_framer #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [31:0] current_time_i,
  input  logic        rx_valid_i,
  input  logic [7:0]  rx_data_i,
  input  logic        parity_error_i,
  input  logic        frame_error_i,
  input  logic [15:0] max_len_i,
  // Result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        store_valid_o,
  output logic [15:0] store_index_o,
  output logic [7:0]  store_data_o,
  output logic        complete_o,
  output logic [15:0] complete_len_o,
  output logic        arm_accepted_o,
  output logic        busy_res_o,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import urxit_pkg::*;

  logic [31:0] idle_to_q, idle_to_d;
  cmd_t        front_cmd, queue_cmd;
  q_status_t   q_status;
  logic        push, pop;
  logic        res_valid;
  res_t        res;

  // Configuration register. Register index is address bit 2; a write to any
  // other index is ignored.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_IDLE_TIMEOUT) ? idle_to_q : 32'd0;

  always_comb begin
    idle_to_d = idle_to_q;
    if (psel && penable && pwrite && (paddr[2] == REG_IDLE_TIMEOUT)) begin
      idle_to_d = pwdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_to_q <= IDLE_TIMEOUT_RST;
    end else begin
      idle_to_q <= idle_to_d;
    end
  end

  // The request is accepted whenever the queue has room.
  assign in_stall_o = q_status.full;
  assign push       = in_valid_i & ~q_status.full;

  urxit_front u_front (
    .req_type_i     (req_type_i),
    .current_time_i (current_time_i),
    .rx_valid_i     (rx_valid_i),
    .rx_data_i      (rx_data_i),
    .parity_error_i (parity_error_i),
    .frame_error_i  (frame_error_i),
    .max_len_i      (max_len_i),
    .cmd_o          (front_cmd)
  );

  urxit_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (front_cmd),
    .pop_i      (pop),
    .pop_cmd_o  (queue_cmd),
    .status_o   (q_status)
  );

  urxit_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .idle_timeout_i (idle_to_q),
    .cmd_valid_i    (~q_status.empty),
    .cmd_i          (queue_cmd),
    .cmd_pop_o      (pop),
    .res_valid_o    (res_valid),
    .res_o          (res),
    .res_stall_i    (out_stall_i)
  );

  assign out_valid_o    = res_valid;
  assign store_valid_o  = res.store_valid;
  assign store_index_o  = res.store_index;
  assign store_data_o   = res.store_data;
  assign complete_o     = res.complete;
  assign complete_len_o = res.complete_len;
  assign arm_accepted_o = res.arm_accepted;
  assign busy_res_o     = res.busy;

`ifndef SYNTHESIS
  // A finished transaction leaves the framer idle.
  a_complete_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && complete_o |-> !busy_res_o)
    else $error("completion reported while still busy");

  // An accepted arm always leaves the framer busy and stores nothing.
  a_arm_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && arm_accepted_o |-> busy_res_o && !store_valid_o && !complete_o)
    else $error("arm acknowledgement inconsistent with result");

  // The queue can never be full and empty at once.
  a_queue_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_status.full && q_status.empty))
    else $error("command queue status corrupt");

  // Nothing is popped from an empty queue.
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_status.empty)
    else $error("command popped from empty queue");
`endif

endmodule

// ===== hdl/urxit_front.sv =====
module urxit_front (
  input  logic [1:0]         req_type_i,
  input  logic [31:0]        current_time_i,
  input  logic               rx_valid_i,
  input  logic [7:0]         rx_data_i,
  input  logic               parity_error_i,
  input  logic               frame_error_i,
  input  logic [15:0]        max_len_i,
  output urxit_pkg::cmd_t    cmd_o
);
  import urxit_pkg::*;

  // A character counts only when it arrived without a line error; the length
  // check of an arm request is settled here so that the back end only sees a flag.
  always_comb begin
    cmd_o         = '0;
    cmd_o.data    = rx_data_i;
    cmd_o.now     = current_time_i;
    cmd_o.len     = max_len_i;
    cmd_o.byte_ok = rx_valid_i & ~parity_error_i & ~frame_error_i;
    cmd_o.len_ok  = (max_len_i != 16'd0) && (max_len_i <= MAX_TRANSFER);
    case (req_e'(req_type_i))
      REQ_TICK: begin
        cmd_o.op = CMD_TICK;
      end
      REQ_ARM: begin
        cmd_o.op = CMD_ARM;
      end
      REQ_ABORT: begin
        cmd_o.op = CMD_ABORT;
      end
      default: begin
        cmd_o.op = CMD_NOP;
      end
    endcase
  end

endmodule

// ===== hdl/urxit_queue.sv =====
module urxit_queue #(
  parameter int DEPTH = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  urxit_pkg::cmd_t       push_cmd_i,
  input  logic                  pop_i,
  output urxit_pkg::cmd_t       pop_cmd_o,
  output urxit_pkg::q_status_t  status_o
);
  import urxit_pkg::*;

  localparam int PTR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign status_o.full  = (cnt_q == CNT_W'(DEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign do_push        = push_i & ~status_o.full;
  assign do_pop         = pop_i & ~status_o.empty;
  assign pop_cmd_o      = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

// ===== hdl/urxit_back.sv =====
module urxit_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [31:0]        idle_timeout_i,
  input  logic               cmd_valid_i,
  input  urxit_pkg::cmd_t    cmd_i,
  output logic               cmd_pop_o,
  output logic               res_valid_o,
  output urxit_pkg::res_t    res_o,
  input  logic               res_stall_i
);
  import urxit_pkg::*;

  logic        armed_q, armed_d;
  logic [15:0] limit_q, limit_d;
  logic [15:0] count_q, count_d;
  logic [31:0] last_q, last_d;
  logic        res_valid_q, res_valid_d;
  res_t        res_q, res_d;

  logic [15:0] cnt_new;
  logic [31:0] last_new;
  logic [31:0] delta;

  // The result register is free when empty or being taken this cycle.
  assign cmd_pop_o = cmd_valid_i & (~res_valid_q | ~res_stall_i);

  assign cnt_new  = cmd_i.byte_ok ? count_q + 16'd1 : count_q;
  assign last_new = cmd_i.byte_ok ? cmd_i.now : last_q;
  assign delta    = cmd_i.now - last_new;

  always_comb begin
    armed_d     = armed_q;
    limit_d     = limit_q;
    count_d     = count_q;
    last_d      = last_q;
    res_d       = '0;
    res_valid_d = res_valid_q & res_stall_i;
    if (cmd_pop_o) begin
      res_valid_d = 1'b1;
      case (cmd_i.op)
        CMD_TICK: begin
          if (armed_q) begin
            count_d = cnt_new;
            last_d  = last_new;
            if (cmd_i.byte_ok) begin
              res_d.store_valid = 1'b1;
              res_d.store_index = count_q;
              res_d.store_data  = cmd_i.data;
            end
            if ((cnt_new >= limit_q) ||
                ((cnt_new != 16'd0) && (delta >= idle_timeout_i))) begin
              res_d.complete     = 1'b1;
              res_d.complete_len = cnt_new;
              armed_d            = 1'b0;
              count_d            = '0;
              last_d             = '0;
            end
          end
        end
        CMD_ARM: begin
          if (cmd_i.len_ok && !armed_q) begin
            res_d.arm_accepted = 1'b1;
            armed_d            = 1'b1;
            limit_d            = cmd_i.len;
            count_d            = '0;
            last_d             = cmd_i.now;
          end
        end
        CMD_ABORT: begin
          if (armed_q) begin
            res_d.complete     = 1'b1;
            res_d.complete_len = count_q;
          end
          armed_d = 1'b0;
          count_d = '0;
          last_d  = '0;
        end
        default: begin
        end
      endcase
      res_d.busy = armed_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q     <= 1'b0;
      limit_q     <= '0;
      count_q     <= '0;
      last_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      armed_q     <= armed_d;
      limit_q     <= limit_d;
      count_q     <= count_d;
      last_q      <= last_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ===== sim/rx_frame_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels and the register port of the receive framer, predicts
// the result of every accepted request and compares the results in order.
module rx_frame_checker
  import urxit_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  req_type_i,
  input  logic [31:0] current_time_i,
  input  logic        rx_valid_i,
  input  logic [7:0]  rx_data_i,
  input  logic        parity_error_i,
  input  logic        frame_error_i,
  input  logic [15:0] max_len_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        store_valid_i,
  input  logic [15:0] store_index_i,
  input  logic [7:0]  store_data_i,
  input  logic        complete_i,
  input  logic [15:0] complete_len_i,
  input  logic        arm_accepted_i,
  input  logic        busy_res_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  input  logic [31:0] prdata_i,
  input  logic        pready_i,
  output int          mismatch_cnt_o,
  output int          results_owed_o
);

  localparam logic [2:0] TMO_ADDR = {REG_IDLE_TIMEOUT, 2'b00};

  // Our own copy of the framer state and its register.
  logic [31:0] idle_tmo;
  logic        armed;
  logic [15:0] limit_len;
  logic [15:0] byte_cnt;
  logic [31:0] last_rx_time;

  res_t predicted_frames[$];

  function automatic res_t frame_request(req_e req, logic [31:0] now, logic rxv,
                                         logic [7:0] data, logic perr, logic ferr,
                                         logic [15:0] mlen);
    res_t r;
    r = '0;
    case (req)
      REQ_TICK: begin
        if (armed) begin
          if (rxv && !perr && !ferr) begin
            r.store_valid = 1'b1;
            r.store_index = byte_cnt;
            r.store_data  = data;
            byte_cnt      = byte_cnt + 16'd1;
            last_rx_time  = now;
          end
          // A full buffer ends the frame; otherwise silence after a byte does.
          if (byte_cnt >= limit_len ||
              (byte_cnt != 16'd0 && (now - last_rx_time) >= idle_tmo)) begin
            r.complete     = 1'b1;
            r.complete_len = byte_cnt;
            armed          = 1'b0;
            byte_cnt       = '0;
            last_rx_time   = '0;
          end
        end
      end
      REQ_ARM: begin
        if (!armed && mlen != 16'd0 && mlen <= MAX_TRANSFER) begin
          r.arm_accepted = 1'b1;
          armed          = 1'b1;
          limit_len      = mlen;
          byte_cnt       = '0;
          last_rx_time   = now;
        end
      end
      REQ_ABORT: begin
        // The count and timestamp are cleared even when nothing was armed.
        if (armed) begin
          r.complete     = 1'b1;
          r.complete_len = byte_cnt;
        end
        armed        = 1'b0;
        byte_cnt     = '0;
        last_rx_time = '0;
      end
      default: ;
    endcase
    r.busy = armed;
    return r;
  endfunction

  task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
      mismatch_cnt_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t got;
    res_t want;
    if (!rst_ni) begin
      idle_tmo     = IDLE_TIMEOUT_RST;
      armed        = 1'b0;
      limit_len    = '0;
      byte_cnt     = '0;
      last_rx_time = '0;
      predicted_frames.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = {store_valid_i, store_index_i, store_data_i, complete_i, complete_len_i,
               arm_accepted_i, busy_res_i};
        if (predicted_frames.size() == 0) begin
          $display("%0t: result %h arrived with none expected", $time, got);
          mismatch_cnt_o++;
        end else begin
          want = predicted_frames.pop_front();
          check_field("store_valid", want.store_valid, got.store_valid);
          check_field("store_index", want.store_index, got.store_index);
          check_field("store_data", want.store_data, got.store_data);
          check_field("complete", want.complete, got.complete);
          check_field("complete_len", want.complete_len, got.complete_len);
          check_field("arm_accepted", want.arm_accepted, got.arm_accepted);
          check_field("busy_res", want.busy, got.busy);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        predicted_frames.push_back(frame_request(req_e'(req_type_i), current_time_i,
                                                 rx_valid_i, rx_data_i, parity_error_i,
                                                 frame_error_i, max_len_i));
      end
      if (psel_i && penable_i && pready_i && paddr_i == TMO_ADDR) begin
        if (pwrite_i) begin
          idle_tmo = pwdata_i;
        end else begin
          check_field("idle_timeout readback", idle_tmo, prdata_i);
        end
      end
    end
    results_owed_o = predicted_frames.size();
  end

endmodule

// ===== sim/uart_rx_idle_timeout_framer_tb.sv =====
`timescale 1ns / 1ps

// Top of the framer regression. This module only produces stimulus and gives
// the verdict; prediction and comparison live in the frame checker beside the
// block. The run has a short directed part followed by random receive frames
// under several idle timeout settings and three patterns of back-pressure.
module uart_rx_idle_timeout_framer_tb;
  import urxit_pkg::*;

  localparam logic [2:0] TMO_ADDR     = {REG_IDLE_TIMEOUT, 2'b00};
  localparam int         LIMIT_CYCLES = 400000;
  localparam int         ITEMS_PER_PHASE = 280;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  req_type_i;
  logic [31:0] current_time_i;
  logic        rx_valid_i;
  logic [7:0]  rx_data_i;
  logic        parity_error_i;
  logic        frame_error_i;
  logic [15:0] max_len_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        store_valid_o;
  logic [15:0] store_index_o;
  logic [7:0]  store_data_o;
  logic        complete_o;
  logic [15:0] complete_len_o;
  logic        arm_accepted_o;
  logic        busy_res_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int          mismatches;
  int          results_owed;

  // Percentages of cycles in which the sender holds back a request and the
  // receiver raises its stall.
  int unsigned send_idle_pct;
  int unsigned stall_pct;

  // The idle timeout currently programmed, and the running tick count used by
  // the random frames.
  logic [31:0] cur_tmo;
  logic [31:0] now_ticks;
  int          frame_items;

  always #6 clk_i = ~clk_i;

  uart_rx_idle_timeout_framer dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .current_time_i (current_time_i),
    .rx_valid_i     (rx_valid_i),
    .rx_data_i      (rx_data_i),
    .parity_error_i (parity_error_i),
    .frame_error_i  (frame_error_i),
    .max_len_i      (max_len_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .store_valid_o  (store_valid_o),
    .store_index_o  (store_index_o),
    .store_data_o   (store_data_o),
    .complete_o     (complete_o),
    .complete_len_o (complete_len_o),
    .arm_accepted_o (arm_accepted_o),
    .busy_res_o     (busy_res_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  rx_frame_checker u_frame_chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .req_type_i     (req_type_i),
    .current_time_i (current_time_i),
    .rx_valid_i     (rx_valid_i),
    .rx_data_i      (rx_data_i),
    .parity_error_i (parity_error_i),
    .frame_error_i  (frame_error_i),
    .max_len_i      (max_len_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .store_valid_i  (store_valid_o),
    .store_index_i  (store_index_o),
    .store_data_i   (store_data_o),
    .complete_i     (complete_o),
    .complete_len_i (complete_len_o),
    .arm_accepted_i (arm_accepted_o),
    .busy_res_i     (busy_res_o),
    .psel_i         (psel),
    .penable_i      (penable),
    .pwrite_i       (pwrite),
    .paddr_i        (paddr),
    .pwdata_i       (pwdata),
    .prdata_i       (prdata),
    .pready_i       (pready),
    .mismatch_cnt_o (mismatches),
    .results_owed_o (results_owed)
  );

  // The receiver stalls at random; the decision is taken at every falling edge
  // so that it is settled well before the block samples it.
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  // Hard limit on the length of the run, far beyond the slowest correct run.
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk_i);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Presents one request and holds it until it is accepted. It is entered and
  // left at a falling edge; a request following straight on keeps valid high.
  task automatic send_req(req_e kind, logic [31:0] now, logic rxv, logic [7:0] data,
                          logic perr, logic ferr, logic [15:0] len);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    req_type_i     <= kind;
    current_time_i <= now;
    rx_valid_i     <= rxv;
    rx_data_i      <= data;
    parity_error_i <= perr;
    frame_error_i  <= ferr;
    max_len_i      <= len;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Stops sending and waits until every predicted result has been taken, then
  // lets the pipeline settle before anything else happens.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (results_owed != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // One APB transfer: a setup phase, then an access phase held until pready.
  task automatic apb_access(logic wr, logic [2:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  // Steps of the tick count: mostly a few ticks, often right around the
  // programmed timeout, and now and then an arbitrary jump across the wrap.
  function automatic logic [31:0] time_step();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return $urandom_range(0, 3);
    end else if (r < 85) begin
      return cur_tmo + $urandom_range(0, 4) - 32'd2;
    end
    return $urandom;
  endfunction

  // A well-formed receive frame with random content: an arm request, a run of
  // ticks mostly carrying characters, and an ending by abort, silence or
  // simply by the buffer or the timeout. Up to two noise requests follow.
  task automatic run_frame();
    int unsigned r;
    int unsigned nticks;
    logic [15:0] len;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      len = 16'($urandom_range(1, 8));
    end else if (r < 80) begin
      len = 16'($urandom_range(9, 40));
    end else if (r < 88) begin
      len = MAX_TRANSFER;
    end else begin
      len = 16'($urandom_range(1, MAX_TRANSFER));
    end
    now_ticks = now_ticks + time_step();
    send_req(REQ_ARM, now_ticks, 1'($urandom_range(0, 1)), 8'($urandom),
             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), len);
    nticks = $urandom_range(1, 24);
    repeat (nticks) begin
      now_ticks = now_ticks + time_step();
      send_req(REQ_TICK, now_ticks, $urandom_range(0, 99) < 85, 8'($urandom),
               $urandom_range(0, 99) < 8, $urandom_range(0, 99) < 8, 16'($urandom));
    end
    frame_items += int'(nticks) + 1;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      now_ticks = now_ticks + time_step();
      send_req(REQ_ABORT, now_ticks, 1'($urandom_range(0, 1)), 8'($urandom),
               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 16'($urandom));
      frame_items++;
    end else if (r < 70) begin
      now_ticks = now_ticks + $urandom;
      send_req(REQ_TICK, now_ticks, 1'b0, 8'($urandom), 1'b0, 1'b0, 16'($urandom));
      frame_items++;
    end
    // Noise: any request code, any field values, including bad arm lengths.
    repeat ($urandom_range(0, 2)) begin
      send_req(req_e'(2'($urandom_range(0, 3))), $urandom, 1'($urandom_range(0, 1)),
               8'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
               16'($urandom));
      frame_items++;
    end
  endtask

  initial begin
    logic [31:0] tmo_plan [6];
    tmo_plan = '{IDLE_TIMEOUT_RST, 32'd0, 32'd7, 32'hFFFF_FFFF, 32'd25, 32'd3};

    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    req_type_i     = REQ_TICK;
    current_time_i = '0;
    rx_valid_i     = 1'b0;
    rx_data_i      = '0;
    parity_error_i = 1'b0;
    frame_error_i  = 1'b0;
    max_len_i      = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    send_idle_pct  = 35;
    stall_pct      = 56;
    cur_tmo        = IDLE_TIMEOUT_RST;
    now_ticks      = '0;
    frame_items    = 0;

    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // The register must come out of reset at its documented value.
    apb_access(1'b0, TMO_ADDR, '0);

    // Directed part, run with the reset timeout of 100000 ticks.
    // A tick while idle is ignored even when it carries a clean character.
    send_req(REQ_TICK, 32'd10, 1'b1, 8'h3C, 1'b0, 1'b0, 16'd0);
    // Abort while idle reports nothing, and request code three is ignored.
    send_req(REQ_ABORT, 32'd11, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0);
    send_req(REQ_NONE, 32'hFFFF_FFFF, 1'b1, 8'hFF, 1'b1, 1'b1, 16'hFFFF);
    // Arm requests with a zero length or a length beyond the buffer are refused.
    send_req(REQ_ARM, 32'd20, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0);
    send_req(REQ_ARM, 32'd21, 1'b0, 8'h00, 1'b0, 1'b0, MAX_TRANSFER + 16'd1);
    send_req(REQ_ARM, 32'd22, 1'b0, 8'h00, 1'b0, 1'b0, 16'hFFFF);
    // The largest buffer is accepted; a second arm while busy is refused.
    send_req(REQ_ARM, 32'hFFFF_FFF0, 1'b0, 8'h00, 1'b0, 1'b0, MAX_TRANSFER);
    send_req(REQ_ARM, 32'hFFFF_FFF0, 1'b0, 8'h00, 1'b0, 1'b0, 16'd1);
    // Characters with a parity or a framing error are dropped.
    send_req(REQ_TICK, 32'hFFFF_FFF1, 1'b1, 8'hFF, 1'b1, 1'b0, 16'd0);
    send_req(REQ_TICK, 32'hFFFF_FFF2, 1'b1, 8'h00, 1'b0, 1'b1, 16'd0);
    // Two clean bytes either side of the wrap of the tick count.
    send_req(REQ_TICK, 32'hFFFF_FFFF, 1'b1, 8'hFF, 1'b0, 1'b0, 16'd0);
    send_req(REQ_TICK, 32'd5, 1'b1, 8'h00, 1'b0, 1'b0, 16'd0);
    // One tick short of the timeout, then exactly on it: the frame ends.
    send_req(REQ_TICK, 32'd100004, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0);
    send_req(REQ_TICK, 32'd100005, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0);
    // A byte that fills a one-byte buffer is stored and completes at once.
    send_req(REQ_ARM, 32'd200000, 1'b0, 8'h00, 1'b0, 1'b0, 16'd1);
    send_req(REQ_TICK, 32'd200001, 1'b1, 8'hA5, 1'b0, 1'b0, 16'd0);
    // Abort while armed reports the count so far.
    send_req(REQ_ARM, 32'd200002, 1'b0, 8'h00, 1'b0, 1'b0, 16'd3);
    send_req(REQ_TICK, 32'd200003, 1'b1, 8'h5A, 1'b1, 1'b1, 16'd0);
    send_req(REQ_TICK, 32'd200004, 1'b1, 8'h5A, 1'b0, 1'b0, 16'd0);
    send_req(REQ_TICK, 32'd300003, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0);
    send_req(REQ_ABORT, 32'd300004, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0);
    send_req(REQ_ABORT, 32'd300005, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0);
    // The largest possible silence, after a byte just past the wrap, ends the frame.
    send_req(REQ_ARM, 32'hFFFF_FFFF, 1'b0, 8'h00, 1'b0, 1'b0, 16'd2);
    send_req(REQ_TICK, 32'd0, 1'b1, 8'hC3, 1'b0, 1'b0, 16'd0);
    send_req(REQ_TICK, 32'hFFFF_FFFF, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0);

    // Random part: two timeout settings under each back-pressure pattern. The
    // register is only touched once the block has gone quiet.
    for (int p = 0; p < 6; p++) begin
      drain();
      case (p / 2)
        0: begin
          send_idle_pct = 35;
          stall_pct     = 56;
        end
        1: begin
          send_idle_pct = 56;
          stall_pct     = 35;
        end
        default: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
      endcase
      cur_tmo = tmo_plan[p];
      apb_access(1'b1, TMO_ADDR, cur_tmo);
      apb_access(1'b0, TMO_ADDR, '0);
      frame_items = 0;
      while (frame_items < ITEMS_PER_PHASE) begin
        // Now and then the sender waits for every outstanding result.
        if ($urandom_range(0, 99) < 3) begin
          drain();
        end
        run_frame();
      end
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/urxit_pkg.sv
hdl/urxit_front.sv
hdl/urxit_queue.sv
hdl/urxit_back.sv
hdl/uart_rx_idle_timeout_framer.sv
sim/rx_frame_checker.sv
sim/uart_rx_idle_timeout_framer_tb.sv
